// ===== sv/sdhr_pkg.sv =====
// Shared constants for the servo drive handshake receiver.
// No dependencies; imported by servo_drive_handshake_receiver_core.
package sdhr_pkg;

	// Default width of the motion code.
	localparam int CODE_BITS_DEF = 3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SHORT_PULSE = 2'd0;
	localparam logic [1:0] CFG_LONG_PULSE  = 2'd1;
	localparam logic [1:0] CFG_FRAME       = 2'd2;

	// Register reset values.
	localparam logic [7:0] SHORT_PULSE_RST = 8'd6;
	localparam logic [7:0] LONG_PULSE_RST  = 8'd20;
	localparam logic [7:0] FRAME_RST       = 8'd200;

	// Motion codes.
	localparam int MC_FWD   = 0;
	localparam int MC_BACK  = 1;
	localparam int MC_LEFT  = 2;
	localparam int MC_RIGHT = 3;
	localparam int MC_STOP  = 4;

	// Frame segment bookkeeping: three segments, then the done marker.
	localparam logic [1:0] SEG_FIRST  = 2'd0;
	localparam logic [1:0] SEG_SECOND = 2'd1;
	localparam logic [1:0] SEG_REST   = 2'd2;
	localparam logic [1:0] SEG_DONE   = 2'd3;

	// Servo level sets, bit 0 is servo one.
	localparam logic [2:0] LVL_NONE  = 3'b000;
	localparam logic [2:0] LVL_ONE   = 3'b001;
	localparam logic [2:0] LVL_TWO   = 3'b010;
	localparam logic [2:0] LVL_ALL   = 3'b111;

	typedef logic [3:0][7:0] seg_len_t;
	typedef logic [3:0][2:0] seg_lvl_t;

	typedef struct packed {
		logic [1:0] seg;
		logic [7:0] cnt;
	} frame_pos_t;

endpackage

// ===== sv/servo_drive_handshake_receiver_core.sv =====
// Servo drive handshake receiver: tick-driven handshake, motion code receiver, servo frames.
// Depends on sdhr_pkg for constants and types.
//
// Channel   Dir   Handshake                       Payload
// s_axis    in    s_axis_tvalid / s_axis_tready   tdata[0] partner_ack, [1] partner_data
// m_axis    out   m_axis_tvalid / m_axis_tready   tdata[9:0] result fields, see port list
// cfg       in    cfg_valid / cfg_ready           cfg_index, cfg_data (8-bit register value)
//
// One tick transaction in, one result transaction out, one per cycle sustained while
// m_axis_tready is high. An input register feeds the state update and output register.
// The whole tick step (phase logic plus up to three frame segment skips) sits between
// those two registers. The output register is stalled by m_axis_tready; the input
// register keeps taking a transaction while the output waits, then back-pressures.
// Reset (arst_n low) puts the handshake in its wait-for-both-high phase, ack and reset
// lines high, registers at their defaults. cfg_ready is always high.
module servo_drive_handshake_receiver_core
	import sdhr_pkg::*;
#(
	parameter int CODE_BITS = CODE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] partner_ack, [1] partner_data, [7:2] zero
	input  logic [7:0]  s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] ack_line, [1] reset_line, [2] servo_one, [3] servo_two, [4] servo_three,
	// [5] code_valid, [8:6] motion_code, [9] mismatch_seen, [15:10] zero
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int BIT_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
	localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(CODE_BITS - 1);

	typedef enum logic [2:0] {
		PH_HS_HIGH,
		PH_HS_LOW,
		PH_BIT_HIGH,
		PH_BIT_LOW,
		PH_ERR_LOW,
		PH_MOTION
	} phase_t;

	// Configuration registers
	logic [7:0] short_q, long_q, frame_q;

	// Tick state
	phase_t               phase_q, phase_n;
	logic                 round_q, round_n;
	logic [BIT_W-1:0]     bit_q, bit_n;
	logic [CODE_BITS-1:0] now_q, now_n;
	logic [CODE_BITS-1:0] before_q, before_n;
	logic [CODE_BITS-1:0] held_q, held_n;
	frame_pos_t           pos_q, pos_n;
	logic                 ack_line_q, ack_line_n;
	logic                 rst_line_q, rst_line_n;

	// Pipeline
	logic        valid_s1;
	logic        pack_s1, pdat_s1;
	logic        out_valid_q;
	logic [15:0] out_data_q;
	logic        advance;
	logic        s_accept;

	// Per-tick outputs
	logic [2:0]  servo;
	logic        code_valid;
	logic        mismatch;

	// Frame tables for the held code
	logic [31:0] code_ext;
	seg_len_t    lens;
	seg_lvl_t    lvls;

	frame_pos_t       p1, p2;
	logic [BIT_W-1:0] bit_pos;

	function automatic logic [7:0] sat_sub(logic [7:0] a, logic [7:0] b);
		return (a > b) ? (a - b) : 8'd0;
	endfunction

	// Low three bits of the held code, zero-extended first for narrow codes.
	function automatic logic [2:0] code_ext_n(logic [CODE_BITS-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return w[2:0];
	endfunction

	// Step past exhausted (or empty) segments; at most three of them.
	function automatic frame_pos_t skip_done(frame_pos_t p, seg_len_t l);
		frame_pos_t r;
		r = p;
		for (int i = 0; i < 3; i++) begin
			if (r.seg != SEG_DONE && r.cnt >= l[r.seg]) begin
				r.seg = r.seg + 2'd1;
				r.cnt = 8'd0;
			end
		end
		return r;
	endfunction

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign code_ext = 32'(held_q);

	always_comb begin
		lens = '0;
		lvls = '0;
		if (code_ext == 32'(MC_FWD) || code_ext == 32'(MC_BACK)) begin
			lens[SEG_FIRST]  = short_q;
			lens[SEG_SECOND] = long_q;
			lens[SEG_REST]   = sat_sub(sat_sub(frame_q, short_q), long_q);
			lvls[SEG_FIRST]  = (code_ext == 32'(MC_FWD)) ? LVL_TWO : LVL_ONE;
			lvls[SEG_SECOND] = (code_ext == 32'(MC_FWD)) ? LVL_ONE : LVL_TWO;
		end else if (code_ext == 32'(MC_LEFT)) begin
			lens[SEG_FIRST]  = long_q;
			lens[SEG_SECOND] = sat_sub(frame_q, long_q);
			lvls[SEG_FIRST]  = LVL_ALL;
		end else if (code_ext == 32'(MC_RIGHT)) begin
			lens[SEG_FIRST]  = short_q;
			lens[SEG_SECOND] = sat_sub(frame_q, short_q);
			lvls[SEG_FIRST]  = LVL_ALL;
		end else if (code_ext == 32'(MC_STOP)) begin
			lens[SEG_FIRST]  = frame_q;
		end
	end

	// Next state for one tick
	always_comb begin
		phase_n    = phase_q;
		round_n    = round_q;
		bit_n      = bit_q;
		now_n      = now_q;
		before_n   = before_q;
		held_n     = held_q;
		pos_n      = pos_q;
		ack_line_n = ack_line_q;
		rst_line_n = rst_line_q;
		servo      = LVL_NONE;
		code_valid = 1'b0;
		mismatch   = 1'b0;
		p1         = pos_q;
		p2         = pos_q;

		if (phase_q == PH_MOTION) begin
			// Partner ack is only honored on a frame boundary.
			if (pos_q.seg == SEG_FIRST && pos_q.cnt == 8'd0 && pack_s1) begin
				phase_n  = PH_BIT_HIGH;
				round_n  = 1'b0;
				bit_n    = '0;
				now_n    = '0;
				before_n = '0;
			end else begin
				p1 = skip_done(pos_q, lens);
				p2 = p1;
				if (p1.seg != SEG_DONE) begin
					servo  = lvls[p1.seg];
					p2.cnt = p1.cnt + 8'd1;
					p2     = skip_done(p2, lens);
				end
				pos_n = (p2.seg == SEG_DONE) ? '0 : p2;
			end
		end

		bit_pos = LAST_BIT - bit_n;

		unique case (phase_n)
			PH_MOTION: begin
			end
			PH_HS_LOW: begin
				if (!pack_s1 && !pdat_s1) begin
					ack_line_n = 1'b0;
					rst_line_n = 1'b0;
					phase_n    = PH_BIT_HIGH;
					round_n    = 1'b0;
					bit_n      = '0;
					now_n      = '0;
					before_n   = '0;
				end
			end
			PH_BIT_HIGH: begin
				if (pack_s1) begin
					now_n[bit_pos] = now_n[bit_pos] | pdat_s1;
					if (round_n && (before_n[bit_pos] != now_n[bit_pos])) begin
						mismatch   = 1'b1;
						ack_line_n = 1'b1;
						rst_line_n = 1'b1;
						phase_n    = PH_ERR_LOW;
					end else begin
						ack_line_n = 1'b1;
						rst_line_n = 1'b0;
						phase_n    = PH_BIT_LOW;
					end
				end
			end
			PH_BIT_LOW: begin
				if (!pack_s1) begin
					ack_line_n = 1'b0;
					rst_line_n = 1'b0;
					phase_n    = PH_BIT_HIGH;
					if (bit_n == LAST_BIT) begin
						bit_n = '0;
						if (!round_n) begin
							before_n = now_n;
							now_n    = '0;
							round_n  = 1'b1;
						end else begin
							held_n     = now_n;
							code_valid = 1'b1;
							round_n    = 1'b0;
							now_n      = '0;
							before_n   = '0;
							phase_n    = PH_MOTION;
							pos_n      = '0;
						end
					end else begin
						bit_n = bit_n + BIT_W'(1);
					end
				end
			end
			PH_ERR_LOW: begin
				if (!pack_s1) begin
					ack_line_n = 1'b0;
					rst_line_n = 1'b0;
					phase_n    = PH_BIT_HIGH;
					round_n    = 1'b0;
					bit_n      = '0;
					now_n      = '0;
					before_n   = '0;
				end
			end
			default: begin
				phase_n = (pack_s1 && pdat_s1) ? PH_HS_LOW : PH_HS_HIGH;
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q <= SHORT_PULSE_RST;
			long_q  <= LONG_PULSE_RST;
			frame_q <= FRAME_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SHORT_PULSE: short_q <= cfg_data;
				CFG_LONG_PULSE:  long_q  <= cfg_data;
				CFG_FRAME:       frame_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Tick state and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HS_HIGH;
			round_q     <= 1'b0;
			bit_q       <= '0;
			now_q       <= '0;
			before_q    <= '0;
			held_q      <= '0;
			pos_q       <= '0;
			ack_line_q  <= 1'b1;
			rst_line_q  <= 1'b1;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= s_accept || (valid_s1 && !advance);
			out_valid_q <= advance || (out_valid_q && !m_axis_tready);
			if (advance) begin
				phase_q    <= phase_n;
				round_q    <= round_n;
				bit_q      <= bit_n;
				now_q      <= now_n;
				before_q   <= before_n;
				held_q     <= held_n;
				pos_q      <= pos_n;
				ack_line_q <= ack_line_n;
				rst_line_q <= rst_line_n;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			pack_s1 <= s_axis_tdata[0];
			pdat_s1 <= s_axis_tdata[1];
		end
		if (advance) begin
			out_data_q <= {6'd0, mismatch, code_ext_n(held_n), code_valid, servo,
				rst_line_n, ack_line_n};
		end
	end

endmodule
